FILE: hdl/mmrs_pkg.sv
// Shared types and constants for the memory map region splitter.
// Used by every module of the block; depends on nothing else.

package mmrs_pkg;

	localparam int DEF_MAP_CAPACITY    = 128;
	localparam int DEF_MAX_DESCRIPTORS = 128;

	// Results a single request can produce, and depth of the job queue.
	localparam int NUM_PIECES  = 3;
	localparam int QUEUE_DEPTH = 2;

	localparam int ADDR_W = 6;
	localparam int DATA_W = 64;

	localparam logic [2:0] REG_KERNEL_START     = 3'd0;
	localparam logic [2:0] REG_KERNEL_END       = 3'd1;
	localparam logic [2:0] REG_INITRD_START     = 3'd2;
	localparam logic [2:0] REG_INITRD_SIZE      = 3'd3;
	localparam logic [2:0] REG_DIRECT_MAP_LIMIT = 3'd4;
	localparam logic [2:0] REG_RAM_TYPE_CODE    = 3'd5;

	localparam logic CMD_REGION = 1'b0;
	localparam logic CMD_FINISH = 1'b1;

	localparam logic KIND_USABLE   = 1'b0;
	localparam logic KIND_RESERVED = 1'b1;

	typedef struct packed {
		logic [63:0] kernel_start;
		logic [63:0] kernel_end;
		logic [63:0] ramdisk_start;
		logic [63:0] initrd_size;
		logic [63:0] direct_map_limit;
		logic [31:0] ram_type_code;
	} cfg_t;

	typedef struct packed {
		logic [63:0] start;
		logic [63:0] length;
		logic        kind;
		logic        valid;
	} piece_t;

	typedef piece_t [NUM_PIECES-1:0] job_t;

	typedef struct packed {
		logic        cmd;
		logic        ram;
		logic        keep;
		logic        wrap;
		logic [63:0] addr_start;
		logic [63:0] addr_end;
		logic [63:0] cursor;
		job_t        pcs;
	} stage_t;

endpackage

FILE: hdl/memory_map_region_splitter.sv
// Top level of the memory map region splitter: register file, front end,
// job queue and back end. Depends on mmrs_pkg and the mmrs_* modules.
//
//   port group   handshake              payload
//   input        in_valid / in_ready    command, region_start, region_size,
//                                       region_type
//   output       out_valid / out_ready  piece_start, piece_length, piece_kind,
//                                       last_piece
//   registers    psel/penable/pwrite    paddr, pwdata, prdata (pready tied high)
//
// A request may follow the previous one in the next cycle unless the front end
// holds. The back end issues one entry per cycle unless the output stalls, so a
// RAM region that splits into three usable pieces occupies it for one issue per
// piece; that single issue port sets the sustained rate.
// Reset clears the counters and the pipeline; no clearing pass is needed.
// A stalled output fills the two-entry queue, then the front end holds.

module memory_map_region_splitter #(
	parameter int MAP_CAPACITY    = mmrs_pkg::DEF_MAP_CAPACITY,
	parameter int MAX_DESCRIPTORS = mmrs_pkg::DEF_MAX_DESCRIPTORS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        command,
	input  logic [63:0]                 region_start,
	input  logic [63:0]                 region_size,
	input  logic [31:0]                 region_type,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [63:0]                 piece_start,
	output logic [63:0]                 piece_length,
	output logic                        piece_kind,
	output logic                        last_piece,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mmrs_pkg::ADDR_W-1:0] paddr,
	input  logic [mmrs_pkg::DATA_W-1:0] pwdata,
	output logic [mmrs_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);

	mmrs_pkg::cfg_t cfg;
	mmrs_pkg::job_t push_job, head;
	logic           push, pop, q_full, q_valid;

	mmrs_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mmrs_front #(
		.MAX_DESCRIPTORS (MAX_DESCRIPTORS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.region_start (region_start),
		.region_size  (region_size),
		.region_type  (region_type),
		.q_full       (q_full),
		.push         (push),
		.push_job     (push_job)
	);

	mmrs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.q_full   (q_full),
		.q_valid  (q_valid),
		.head     (head)
	);

	mmrs_back #(
		.MAP_CAPACITY (MAP_CAPACITY)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.head         (head),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.piece_start  (piece_start),
		.piece_length (piece_length),
		.piece_kind   (piece_kind),
		.last_piece   (last_piece)
	);

endmodule

FILE: hdl/mmrs_regs.sv
// Configuration register file behind the APB-style port.
// Depends on mmrs_pkg for the register map and the cfg_t bundle.

module mmrs_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mmrs_pkg::ADDR_W-1:0] paddr,
	input  logic [mmrs_pkg::DATA_W-1:0] pwdata,
	output logic [mmrs_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output mmrs_pkg::cfg_t              cfg
);

	logic [2:0] reg_idx;
	logic       wr_en;

	assign reg_idx = paddr[mmrs_pkg::ADDR_W-1:3];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.kernel_start     <= 64'h0000_0000_0010_0000;
			cfg.kernel_end       <= 64'd0;
			cfg.ramdisk_start    <= 64'd0;
			cfg.initrd_size      <= 64'd0;
			cfg.direct_map_limit <= 64'h0000_0001_0000_0000;
			cfg.ram_type_code    <= 32'd1;
		end else if (wr_en) begin
			unique case (reg_idx)
				mmrs_pkg::REG_KERNEL_START:     cfg.kernel_start     <= pwdata;
				mmrs_pkg::REG_KERNEL_END:       cfg.kernel_end       <= pwdata;
				mmrs_pkg::REG_INITRD_START:     cfg.ramdisk_start    <= pwdata;
				mmrs_pkg::REG_INITRD_SIZE:      cfg.initrd_size      <= pwdata;
				mmrs_pkg::REG_DIRECT_MAP_LIMIT: cfg.direct_map_limit <= pwdata;
				mmrs_pkg::REG_RAM_TYPE_CODE:    cfg.ram_type_code    <= pwdata[31:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			mmrs_pkg::REG_KERNEL_START:     prdata = cfg.kernel_start;
			mmrs_pkg::REG_KERNEL_END:       prdata = cfg.kernel_end;
			mmrs_pkg::REG_INITRD_START:     prdata = cfg.ramdisk_start;
			mmrs_pkg::REG_INITRD_SIZE:      prdata = cfg.initrd_size;
			mmrs_pkg::REG_DIRECT_MAP_LIMIT: prdata = cfg.direct_map_limit;
			mmrs_pkg::REG_RAM_TYPE_CODE:    prdata = {32'd0, cfg.ram_type_code};
			default:                        prdata = '0;
		endcase
	end

endmodule

FILE: hdl/mmrs_front.sv
// Front end: accepts requests, checks and clips regions, and works out up to
// three candidate map entries in a four-stage pipeline. Depends on mmrs_pkg.

module mmrs_front #(
	parameter int MAX_DESCRIPTORS = mmrs_pkg::DEF_MAX_DESCRIPTORS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  mmrs_pkg::cfg_t cfg,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           command,
	input  logic [63:0]    region_start,
	input  logic [63:0]    region_size,
	input  logic [31:0]    region_type,
	input  logic           q_full,
	output logic           push,
	output mmrs_pkg::job_t push_job
);

	localparam int DcW = $clog2(MAX_DESCRIPTORS + 1);

	logic [DcW-1:0] desc_cnt_q;
	logic [63:0]    sp0_start_q, sp0_end_q, sp1_start_q, sp1_end_q;
	logic [63:0]    ramdisk_end;
	logic           swap;

	mmrs_pkg::stage_t s1_d, s2_d, s3_d, s4_d, tail_d;
	mmrs_pkg::stage_t st_s1, st_s2, st_s3, st_s4;
	logic             vld_s1, vld_s2, vld_s3, vld_s4;
	logic             en, accept, push_need, desc_ok;
	logic             hit0, hit1;
	logic [64:0]      sum;

	// Spans are re-sorted every cycle. The user changes configuration only while
	// idle; the block does not enforce it. A request then sees settled values.
	assign ramdisk_end = cfg.ramdisk_start + cfg.initrd_size;
	assign swap        = cfg.ramdisk_start < cfg.kernel_start;

	always_ff @(posedge clk) begin
		sp0_start_q <= swap ? cfg.ramdisk_start : cfg.kernel_start;
		sp0_end_q   <= swap ? ramdisk_end       : cfg.kernel_end;
		sp1_start_q <= swap ? cfg.kernel_start  : cfg.ramdisk_start;
		sp1_end_q   <= swap ? cfg.kernel_end    : ramdisk_end;
	end

	assign en       = !(vld_s4 && push_need && q_full);
	assign in_ready = en;
	assign accept   = in_valid && en;
	assign desc_ok  = desc_cnt_q < DcW'(MAX_DESCRIPTORS);
	assign sum      = {1'b0, region_start} + {1'b0, region_size};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			desc_cnt_q <= '0;
		end else if (accept && command == mmrs_pkg::CMD_REGION && desc_ok) begin
			desc_cnt_q <= desc_cnt_q + 1'b1;
		end
	end

	// Stage 1: capture, region end and type match.
	always_comb begin
		s1_d            = '0;
		s1_d.cmd        = command;
		s1_d.ram        = region_type == cfg.ram_type_code;
		s1_d.keep       = desc_ok;
		s1_d.wrap       = sum[64];
		s1_d.addr_start = region_start;
		s1_d.addr_end   = sum[63:0];
		s1_d.cursor     = region_start;
	end

	// Stage 2: drop and clip, and the finish entries.
	always_comb begin
		s2_d = st_s1;
		if (st_s1.cmd == mmrs_pkg::CMD_FINISH) begin
			s2_d.keep          = 1'b1;
			s2_d.pcs[0].start  = sp0_start_q;
			s2_d.pcs[0].length = sp0_end_q - sp0_start_q;
			s2_d.pcs[0].kind   = mmrs_pkg::KIND_RESERVED;
			s2_d.pcs[0].valid  = 1'b1;
			s2_d.pcs[1].start  = sp1_start_q;
			s2_d.pcs[1].length = sp1_end_q - sp1_start_q;
			s2_d.pcs[1].kind   = mmrs_pkg::KIND_RESERVED;
			s2_d.pcs[1].valid  = sp1_end_q > sp1_start_q;
		end else begin
			s2_d.keep = st_s1.keep && !st_s1.wrap
				&& (st_s1.addr_start < cfg.direct_map_limit);
			if (st_s1.addr_end > cfg.direct_map_limit) begin
				s2_d.addr_end = cfg.direct_map_limit;
			end
		end
	end

	// Stage 3: whole reserved region, or the gap before the first span.
	always_comb begin
		s3_d = st_s2;
		hit0 = st_s2.addr_start < st_s2.addr_end && sp0_end_q > st_s2.addr_start
			&& sp0_start_q < st_s2.addr_end;
		if (st_s2.cmd == mmrs_pkg::CMD_REGION) begin
			if (st_s2.ram) begin
				s3_d.pcs[0].start  = st_s2.addr_start;
				s3_d.pcs[0].length = sp0_start_q - st_s2.addr_start;
				s3_d.pcs[0].kind   = mmrs_pkg::KIND_USABLE;
				s3_d.pcs[0].valid  = hit0 && sp0_start_q > st_s2.addr_start;
				s3_d.cursor        = hit0 ? sp0_end_q : st_s2.addr_start;
			end else begin
				s3_d.pcs[0].start  = st_s2.addr_start;
				s3_d.pcs[0].length = st_s2.addr_end - st_s2.addr_start;
				s3_d.pcs[0].kind   = mmrs_pkg::KIND_RESERVED;
				s3_d.pcs[0].valid  = 1'b1;
			end
		end
	end

	// Stage 4: gap before the second span.
	always_comb begin
		s4_d              = st_s3;
		s4_d.pcs[0].valid = st_s3.pcs[0].valid && (st_s3.pcs[0].length != 64'd0);
		hit1 = st_s3.cursor < st_s3.addr_end && sp1_end_q > st_s3.cursor
			&& sp1_start_q < st_s3.addr_end;
		if (st_s3.cmd == mmrs_pkg::CMD_REGION && st_s3.ram) begin
			s4_d.pcs[1].start  = st_s3.cursor;
			s4_d.pcs[1].length = sp1_start_q - st_s3.cursor;
			s4_d.pcs[1].kind   = mmrs_pkg::KIND_USABLE;
			s4_d.pcs[1].valid  = hit1 && sp1_start_q > st_s3.cursor;
			s4_d.cursor        = hit1 ? sp1_end_q : st_s3.cursor;
		end
	end

	// Tail piece, then the job goes into the queue.
	always_comb begin
		tail_d              = st_s4;
		tail_d.pcs[1].valid = st_s4.pcs[1].valid && (st_s4.pcs[1].length != 64'd0);
		if (st_s4.cmd == mmrs_pkg::CMD_REGION && st_s4.ram) begin
			tail_d.pcs[2].start  = st_s4.cursor;
			tail_d.pcs[2].length = st_s4.addr_end - st_s4.cursor;
			tail_d.pcs[2].kind   = mmrs_pkg::KIND_USABLE;
			tail_d.pcs[2].valid  = st_s4.cursor < st_s4.addr_end;
		end
		for (int i = 0; i < mmrs_pkg::NUM_PIECES; i++) begin
			tail_d.pcs[i].valid = tail_d.pcs[i].valid && st_s4.keep;
		end
	end

	always_comb begin
		push_need = 1'b0;
		for (int i = 0; i < mmrs_pkg::NUM_PIECES; i++) begin
			push_need = push_need | tail_d.pcs[i].valid;
		end
	end

	assign push     = vld_s4 && push_need && !q_full;
	assign push_job = tail_d.pcs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s1 <= s1_d;
			st_s2 <= s2_d;
			st_s3 <= s3_d;
			st_s4 <= s4_d;
		end
	end

endmodule

FILE: hdl/mmrs_queue.sv
// Short job queue between the front end and the back end.
// Depends on mmrs_pkg for the job type and its depth.

module mmrs_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mmrs_pkg::job_t push_job,
	input  logic           pop,
	output logic           q_full,
	output logic           q_valid,
	output mmrs_pkg::job_t head
);

	localparam int Depth = mmrs_pkg::QUEUE_DEPTH;
	localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW  = $clog2(Depth + 1);

	mmrs_pkg::job_t mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] cnt_q;
	logic            do_pop;

	assign q_full  = cnt_q == CntW'(Depth);
	assign q_valid = cnt_q != '0;
	assign head    = mem_q[rd_ptr_q];
	assign do_pop  = pop && q_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: hdl/mmrs_back.sv
// Back end: issues the valid entries of each job one per cycle unless stalled,
// through an output register, applying the map capacity. Depends on mmrs_pkg.

module mmrs_back #(
	parameter int MAP_CAPACITY = mmrs_pkg::DEF_MAP_CAPACITY
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  mmrs_pkg::job_t head,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [63:0]    piece_start,
	output logic [63:0]    piece_length,
	output logic           piece_kind,
	output logic           last_piece
);

	localparam int EcW = $clog2(MAP_CAPACITY + 1);
	localparam int Np  = mmrs_pkg::NUM_PIECES;

	mmrs_pkg::job_t  cur_q;
	logic [Np-1:0]   mask_q, mask_nx, head_mask;
	logic [EcW-1:0]  ent_q;
	logic            load_ok, cap_full, emit, last_nx;
	mmrs_pkg::piece_t sel_pc;
	logic [Np-1:0]   sel_bit;

	assign load_ok  = !out_valid || out_ready;
	assign cap_full = ent_q >= EcW'(MAP_CAPACITY);

	always_comb begin
		sel_bit = '0;
		sel_pc  = cur_q[0];
		for (int i = Np - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				sel_bit = '0;
				sel_bit[i] = 1'b1;
				sel_pc = cur_q[i];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < Np; i++) begin
			head_mask[i] = head[i].valid;
		end
	end

	// Once the map is full the rest of the job is thrown away uncounted.
	always_comb begin
		emit    = 1'b0;
		mask_nx = mask_q;
		if (mask_q != '0) begin
			if (cap_full) begin
				mask_nx = '0;
			end else if (load_ok) begin
				emit    = 1'b1;
				mask_nx = mask_q & ~sel_bit;
			end
		end
	end

	assign last_nx = (mask_nx == '0) || (ent_q + 1'b1 == EcW'(MAP_CAPACITY));
	assign pop     = q_valid && (mask_nx == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q    <= '0;
			ent_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			mask_q <= pop ? head_mask : mask_nx;
			if (emit) begin
				ent_q     <= ent_q + 1'b1;
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if (emit) begin
			piece_start  <= sel_pc.start;
			piece_length <= sel_pc.length;
			piece_kind   <= sel_pc.kind;
			last_piece   <= last_nx;
		end
	end

endmodule

FILE: hdl/mmrs_checker.sv
// Port-level checks for the memory map region splitter, bound to its top level.
// Depends on mmrs_pkg for the entry kind codes.

module mmrs_port_checks (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] piece_start,
	input logic [63:0] piece_length,
	input logic        piece_kind,
	input logic        last_piece,
	input logic        pready
);

	// A stalled entry must neither vanish nor change.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(piece_start)
		&& $stable(piece_length) && $stable(piece_kind) && $stable(last_piece))
		else $error("output entry changed while stalled");

	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> piece_length != 64'd0)
		else $error("zero-length entry issued");

	// Usable pieces lie inside a clipped region, so they never run past 2^64.
	a_usable_no_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && piece_kind == mmrs_pkg::KIND_USABLE
		|-> (65'(piece_start) + 65'(piece_length)) <= {1'b1, 64'd0})
		else $error("usable entry wraps the address space");

	a_pready_high: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("register port not ready");

endmodule

bind memory_map_region_splitter mmrs_port_checks u_mmrs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.piece_start  (piece_start),
	.piece_length (piece_length),
	.piece_kind   (piece_kind),
	.last_piece   (last_piece),
	.pready       (pready)
);
